// ===== rtl/pointer_speed_smoother_defines.svh =====
// Assertion macros for the pointer speed smoother
`ifndef POINTER_SPEED_SMOOTHER_DEFINES_SVH
`define POINTER_SPEED_SMOOTHER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PSS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication checked on every clock edge outside reset
`define PSS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/pss_pkg.sv =====
// Shared types and constants for the pointer speed smoother
package pss_pkg;
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_CAP    = 2'd1;
    localparam logic [1:0] REG_FLOOR  = 2'd2;
    localparam logic [1:0] REG_ALPHA  = 2'd3;
    localparam logic [23:0] WINDOW_RST = 24'd500000;
    localparam logic [23:0] CAP_RST    = 24'd76800;
    localparam logic [23:0] FLOOR_RST  = 24'd1280;
    localparam logic [16:0] ALPHA_RST  = 17'd13107;
    localparam logic [16:0] ALPHA_ONE  = 17'd65536;
    localparam logic [17:0] SPEED_SCALE = 18'd256000;
    typedef struct packed {
        logic [23:0] window;
        logic [23:0] cap;
        logic [23:0] floor_d;
        logic [16:0] alpha;
    } t_cfg;
endpackage

// ===== rtl/pss_regs.sv =====
// APB register file for the pointer speed smoother
module pss_regs
    import pss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    t_cfg r_cfg;
    logic [1:0] w_idx;
    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window  <= WINDOW_RST;
            r_cfg.cap     <= CAP_RST;
            r_cfg.floor_d <= FLOOR_RST;
            r_cfg.alpha   <= ALPHA_RST;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_WINDOW: r_cfg.window  <= pwdata[23:0];
                REG_CAP:    r_cfg.cap     <= pwdata[23:0];
                REG_FLOOR:  r_cfg.floor_d <= pwdata[23:0];
                REG_ALPHA:  r_cfg.alpha   <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // read-back
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_WINDOW: prdata = {8'd0, r_cfg.window};
            REG_CAP:    prdata = {8'd0, r_cfg.cap};
            REG_FLOOR:  prdata = {8'd0, r_cfg.floor_d};
            REG_ALPHA:  prdata = {15'd0, r_cfg.alpha};
            default:    prdata = '0;
        endcase
    end
endmodule

// ===== rtl/pointer_speed_smoother.sv =====
// Pointer speed smoother: distance history and smoothed speed estimate
// Squares, bit-serial square root, history push, walk back over history, decide,
// restoring divide and average. Without a speed update the old speed is sent; from
// the origin zero is sent. A new point is taken only once the result is accepted.
// Synchronous active-low reset clears the point, ring write pointer, count and
// speed; configuration returns to its defaults. No clearing pass.
module pointer_speed_smoother
    import pss_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // x_pos[23:0], y_pos[47:24], timestamp_us[79:48]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // speed[31:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(HISTORY_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0, S_SQ1 = 4'd1, S_SQ2 = 4'd2, S_ROOT = 4'd3,
        S_PUSH = 4'd4, S_RD = 4'd5, S_WALK = 4'd6, S_DIVP = 4'd7, S_DIV = 4'd8,
        S_MIX1 = 4'd9, S_MIX2 = 4'd10, S_OUT = 4'd11;

    t_cfg cfg;
    pss_regs u_regs (.i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
                     .prdata, .pready, .o_cfg(cfg));

    logic [24:0] r_ring_d [HISTORY_DEPTH];
    logic [31:0] r_ring_t [HISTORY_DEPTH];
    logic [24:0] r_rd_d;
    logic [31:0] r_rd_t;

    logic [3:0]    r_state;
    logic [CW-1:0] r_count, r_k;
    logic [IW-1:0] r_widx, r_pos;
    logic [23:0]   r_px, r_py;
    logic [31:0]   r_now, r_start, r_speed, r_quo;
    logic signed [24:0] r_dx, r_dy;
    logic [49:0]   r_sq, r_rem, r_root, r_rbit;
    logic [29:0]   r_total;
    logic [63:0]   r_num;
    logic [32:0]   r_drem;
    logic [5:0]    r_cnt;
    logic [48:0]   r_m1, r_m2;

    logic [49:0] w_trial;
    logic [32:0] w_dsh;
    logic [29:0] w_tsum;
    logic [31:0] w_age;
    logic [16:0] w_alpha;
    logic [IW-1:0] w_prev;
    logic signed [49:0] w_sqx, w_sqy;
    logic [47:0] w_scaled;

    assign w_trial = r_root + r_rbit;
    assign w_dsh   = {r_drem[31:0], r_num[63]};
    assign w_tsum  = r_total + {5'd0, r_rd_d};
    assign w_age   = r_now - r_rd_t;
    assign w_alpha = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
    assign w_prev  = (r_pos == '0) ? LAST_IDX : r_pos - 1'b1;
    assign w_sqx   = r_dx * r_dx;
    assign w_sqy   = r_dy * r_dy;
    assign w_scaled = r_total * SPEED_SCALE;

    assign s_axis_tready = (r_state == S_IDLE) && !m_axis_tvalid;

    // ring memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH) begin
            r_ring_d[r_widx] <= r_root[24:0];
            r_ring_t[r_widx] <= r_now;
        end
        r_rd_d <= r_ring_d[r_pos];
        r_rd_t <= r_ring_t[r_pos];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_widx  <= '0;
            r_px    <= '0;
            r_py    <= '0;
            r_speed <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_now <= s_axis_tdata[79:48];
                    r_px  <= s_axis_tdata[23:0];
                    r_py  <= s_axis_tdata[47:24];
                    if (r_px == '0 && r_py == '0) begin
                        m_axis_tdata  <= '0;
                        m_axis_tvalid <= 1'b1;
                    end else begin
                        r_dx <= $signed({s_axis_tdata[23], s_axis_tdata[23:0]})
                              - $signed({r_px[23], r_px});
                        r_dy <= $signed({s_axis_tdata[47], s_axis_tdata[47:24]})
                              - $signed({r_py[23], r_py});
                        r_state <= S_SQ1;
                    end
                end
                S_SQ1: begin
                    r_sq    <= $unsigned(w_sqx);
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_rem   <= r_sq + $unsigned(w_sqy);
                    r_root  <= '0;
                    r_rbit  <= 50'd1 << 48;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    // one result bit a cycle
                    if (r_rem >= w_trial) begin
                        r_rem  <= r_rem - w_trial;
                        r_root <= (r_root >> 1) + r_rbit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_rbit <= r_rbit >> 2;
                    if (r_rbit[0]) r_state <= S_PUSH;
                end
                S_PUSH: begin
                    r_widx  <= (r_widx == LAST_IDX) ? '0 : r_widx + 1'b1;
                    r_pos   <= r_widx;
                    if (r_count != DEPTH_C) r_count <= r_count + 1'b1;
                    r_k     <= '0;
                    r_total <= '0;
                    r_start <= r_now;
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_WALK;
                S_WALK: begin
                    // one history entry a visit
                    if (r_k == r_count || w_age > {8'd0, cfg.window}) begin
                        r_state <= S_DIVP;
                    end else begin
                        r_total <= w_tsum;
                        r_start <= r_rd_t;
                        r_k     <= r_k + 1'b1;
                        r_pos   <= w_prev;
                        r_state <= (w_tsum > {6'd0, cfg.cap}) ? S_DIVP : S_RD;
                    end
                end
                S_DIVP: begin
                    if ((r_now - r_start) != '0 && r_total > {6'd0, cfg.floor_d}) begin
                        r_num   <= {16'd0, w_scaled};
                        r_drem  <= '0;
                        r_cnt   <= '0;
                        r_start <= r_now - r_start;
                        r_state <= S_DIV;
                    end else begin
                        m_axis_tdata  <= r_speed;
                        m_axis_tvalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit a cycle
                    if (w_dsh >= {1'b0, r_start}) begin
                        r_drem <= w_dsh - {1'b0, r_start};
                        r_num  <= {r_num[62:0], 1'b1};
                    end else begin
                        r_drem <= w_dsh;
                        r_num  <= {r_num[62:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd63) r_state <= S_MIX1;
                end
                S_MIX1: begin
                    r_quo   <= (r_num[63:32] != '0) ? '1 : r_num[31:0];
                    r_state <= S_MIX2;
                end
                S_MIX2: begin
                    r_m1 <= r_quo * w_alpha;
                    r_m2 <= r_speed * (ALPHA_ONE - w_alpha);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_speed <= 32'(({1'b0, r_m1} + {1'b0, r_m2} + 50'd32768) >> 16);
                    m_axis_tdata  <= 32'(({1'b0, r_m1} + {1'b0, r_m2} + 50'd32768) >> 16);
                    m_axis_tvalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/pss_checker.sv =====
// Port-level checks for the pointer speed smoother
module pss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        pready
);
`include "pointer_speed_smoother_defines.svh"
    `PSS_ASSERT_IMP(a_pready, i_clk, i_rst_n, 1'b1, pready)
    `PSS_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `PSS_ASSERT_NXT(a_busy_after, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `PSS_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind pointer_speed_smoother pss_checker u_chk (.i_clk, .i_rst_n, .s_axis_tvalid,
    .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .pready);
